[rtl/core/knps_pkg.sv]
// shared types and constants of the k-nearest point selector
package knps_pkg;

  localparam int ID_W        = 16;
  localparam int WANT_W      = 5;
  localparam int ELIG_W      = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [ELIG_W-1:0] ELIG_MAX = {ELIG_W{1'b1}};

  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_X,
    CFG_REF_Y,
    CFG_REF_Z,
    CFG_WANTED
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ENTRY,
    STAT_TOO_FEW,
    STAT_NONE
  } status_t;

  typedef enum logic {
    BK_COLLECT,
    BK_EMIT
  } back_state_t;

endpackage

[rtl/core/knps_cand_if.sv]
// candidate channel: valid/ready with one candidate or end item per beat
interface knps_cand_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [knps_pkg::ID_W-1:0]    cand_id;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         is_reserved;

  modport source (
    output valid, kind, cand_id, pos_x, pos_y, pos_z, is_reserved,
    input  ready
  );
  modport sink (
    input  valid, kind, cand_id, pos_x, pos_y, pos_z, is_reserved,
    output ready
  );
endinterface

[rtl/core/knps_res_if.sv]
// result channel: valid/ready with one selected point or status per beat
interface knps_res_if #(
  parameter int DIST_W = 50
);
  logic                          valid;
  logic                          ready;
  logic [knps_pkg::ID_W-1:0]     found_id;
  logic [DIST_W-1:0]             found_dist_sq;
  logic [knps_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (
    output valid, found_id, found_dist_sq, status, last,
    input  ready
  );
  modport sink (
    input  valid, found_id, found_dist_sq, status, last,
    output ready
  );
endinterface

[rtl/core/knps_front.sv]
// front end: drops reserved candidates and computes squared distance in three stages
module knps_front #(
  parameter int COORD_BITS = 24,
  parameter int DIST_W     = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  knps_cand_if.sink                    cand,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic signed [COORD_BITS-1:0] ref_z,
  input  logic                         q_full,
  output logic                         q_push,
  output logic                         q_kind,
  output logic [knps_pkg::ID_W-1:0]    q_id,
  output logic [DIST_W-1:0]            q_dist
);
  import knps_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;

  logic              advance;
  logic              keep;
  logic [MAG_W-1:0]  mag_x, mag_y, mag_z;

  // stage 1: absolute axis differences
  logic              v1, kind1;
  logic [ID_W-1:0]   id1;
  logic [MAG_W-1:0]  ax, ay, az;
  // stage 2: squares
  logic              v2, kind2;
  logic [ID_W-1:0]   id2;
  logic [DIST_W-1:0] sx, sy, sz;
  // stage 3: sum
  logic              v3, kind3;
  logic [ID_W-1:0]   id3;
  logic [DIST_W-1:0] dist3;

  function automatic logic [COORD_BITS:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
  endfunction

  // whole pipe moves together, held only when the last stage cannot enter the queue
  assign advance    = !v3 || !q_full;
  assign cand.ready = advance;
  assign keep       = cand.valid && (cand.kind == KIND_END || !cand.is_reserved);

  assign mag_x = abs_diff(cand.pos_x, ref_x);
  assign mag_y = abs_diff(cand.pos_y, ref_y);
  assign mag_z = abs_diff(cand.pos_z, ref_z);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= keep;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      kind1 <= cand.kind;
      id1   <= cand.cand_id;
      ax    <= mag_x;
      ay    <= mag_y;
      az    <= mag_z;
      kind2 <= kind1;
      id2   <= id1;
      sx    <= ax * ax;
      sy    <= ay * ay;
      sz    <= az * az;
      kind3 <= kind2;
      id3   <= id2;
      dist3 <= sx + sy + sz;
    end
  end

  assign q_push = v3 && !q_full;
  assign q_kind = kind3;
  assign q_id   = id3;
  assign q_dist = dist3;
endmodule

[rtl/core/knps_queue.sv]
// short fifo between the distance front end and the selection back end
module knps_queue #(
  parameter int W = 67
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head_data
);
  import knps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[rtl/core/knps_back.sv]
// back end: sorted insertion row of kept points and answer sequencer
module knps_back #(
  parameter int MAX_WANTED = 16,
  parameter int DIST_W     = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [knps_pkg::WANT_W-1:0]   wanted_count,
  input  logic                          head_valid,
  input  logic                          head_kind,
  input  logic [knps_pkg::ID_W-1:0]     head_id,
  input  logic [DIST_W-1:0]             head_dist,
  output logic                          pop,
  knps_res_if.source                    res
);
  import knps_pkg::*;

  localparam int CNT_W = $clog2(MAX_WANTED + 1);
  localparam int IDX_W = (MAX_WANTED > 1) ? $clog2(MAX_WANTED) : 1;

  logic [ID_W-1:0]       kept_ids   [MAX_WANTED];
  logic [DIST_W-1:0]     kept_dists [MAX_WANTED];
  logic [CNT_W-1:0]      kept_count;
  logic [ELIG_W-1:0]     eligible_count;
  back_state_t           state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;

  logic [CNT_W-1:0]      k;
  logic [CNT_W-1:0]      cnt;
  logic [MAX_WANTED-1:0] le;
  logic                  accept;
  logic                  take_cand;
  logic                  clear;
  logic                  load_ok;
  logic                  load;
  logic [ID_W-1:0]       load_id;
  logic [DIST_W-1:0]     load_dist;
  status_t               load_status;
  logic                  load_last;
  logic                  short_set;
  logic                  last_idx;

  // effective count saturates at the row length
  assign k   = (32'(wanted_count) > 32'(MAX_WANTED)) ? CNT_W'(MAX_WANTED)
                                                      : CNT_W'(wanted_count);
  assign cnt = (kept_count > k) ? k : kept_count;

  // each cell: is it at or before the newcomer (ties keep arrival order)
  always_comb begin
    accept = 1'b0;
    for (int i = 0; i < MAX_WANTED; i++) begin
      le[i] = (i < 32'(cnt)) && (kept_dists[i] <= head_dist);
      if ((i < 32'(k)) && !le[i]) begin
        accept = 1'b1;
      end
    end
  end

  assign take_cand = (state == BK_COLLECT) && head_valid && (head_kind == KIND_CAND);
  assign load_ok   = !res.valid || res.ready;
  assign short_set = (32'(eligible_count) < 32'(k)) || (kept_count < k);
  assign last_idx  = (32'(idx) + 32'd1) == 32'(k);

  // sequencer: next state, queue pop and result load
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pop         = 1'b0;
    clear       = 1'b0;
    load        = 1'b0;
    load_id     = '0;
    load_dist   = '0;
    load_status = STAT_ENTRY;
    load_last   = 1'b0;
    unique case (state)
      BK_COLLECT: begin
        if (head_valid && head_kind == KIND_CAND) begin
          pop = 1'b1;
        end else if (head_valid && load_ok) begin
          if (k == '0) begin
            load        = 1'b1;
            load_status = STAT_NONE;
            load_last   = 1'b1;
            pop         = 1'b1;
            clear       = 1'b1;
          end else if (short_set) begin
            load        = 1'b1;
            load_status = STAT_TOO_FEW;
            load_last   = 1'b1;
            pop         = 1'b1;
            clear       = 1'b1;
          end else begin
            state_next = BK_EMIT;
            idx_next   = '0;
          end
        end
      end
      BK_EMIT: begin
        if (load_ok) begin
          load      = 1'b1;
          load_id   = kept_ids[idx];
          load_dist = kept_dists[idx];
          load_last = last_idx;
          if (last_idx) begin
            pop        = 1'b1;
            clear      = 1'b1;
            state_next = BK_COLLECT;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = BK_COLLECT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_COLLECT;
      idx            <= '0;
      kept_count     <= '0;
      eligible_count <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (clear) begin
        kept_count     <= '0;
        eligible_count <= '0;
      end else if (take_cand) begin
        if (eligible_count != ELIG_MAX) begin
          eligible_count <= eligible_count + 1'b1;
        end
        if (k != '0) begin
          kept_count <= (accept && cnt < k) ? cnt + 1'b1 : cnt;
        end
      end
    end
  end

  // insertion row: cells past the insertion point shift down by one
  for (genvar i = 0; i < MAX_WANTED; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (take_cand && accept && !le[i]) begin
        if (i == 0) begin
          kept_ids[i]   <= head_id;
          kept_dists[i] <= head_dist;
        end else if (le[(i > 0) ? i - 1 : 0]) begin
          kept_ids[i]   <= head_id;
          kept_dists[i] <= head_dist;
        end else begin
          kept_ids[i]   <= kept_ids[(i > 0) ? i - 1 : 0];
          kept_dists[i] <= kept_dists[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_ok) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.found_id      <= load_id;
      res.found_dist_sq <= load_dist;
      res.status        <= load_status;
      res.last          <= load_last;
    end
  end
endmodule

[rtl/core/k_nearest_point_selector_unit.sv]
// top level of the k-nearest point selector: config registers, front end, queue, back end
// a candidate passes the 3-stage distance pipe and the queue before it reaches the kept list
// throughput: one candidate per cycle while the back end collects and the queue is not full
// an end item answers with k beats, one per cycle while the result channel is ready;
// a too-few or none-requested status is a single beat;
// candidates behind it wait in the queue until the last answer beat is loaded for output
// reset: control state cleared, ref_x/y/z to 0, wanted_count to 1, kept list contents undefined
module k_nearest_point_selector_unit #(
  parameter int MAX_WANTED = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  knps_cand_if.sink                           cand,
  knps_res_if.source                          result,
  input  logic                                cfg_we,
  input  logic [knps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);
  import knps_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int QW     = 1 + ID_W + DIST_W;

  logic signed [COORD_BITS-1:0] ref_x, ref_y, ref_z;
  logic [WANT_W-1:0]            wanted_count;

  logic              q_push, q_full, q_pop, q_not_empty, q_kind;
  logic [ID_W-1:0]   q_id;
  logic [DIST_W-1:0] q_dist;
  logic [QW-1:0]     head_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x        <= '0;
      ref_y        <= '0;
      ref_z        <= '0;
      wanted_count <= WANT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REF_X:  ref_x        <= cfg_data;
        CFG_REF_Y:  ref_y        <= cfg_data;
        CFG_REF_Z:  ref_z        <= cfg_data;
        CFG_WANTED: wanted_count <= cfg_data[WANT_W-1:0];
        default:    ;
      endcase
    end
  end

  knps_front #(
    .COORD_BITS (COORD_BITS),
    .DIST_W     (DIST_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand),
    .ref_x  (ref_x),
    .ref_y  (ref_y),
    .ref_z  (ref_z),
    .q_full (q_full),
    .q_push (q_push),
    .q_kind (q_kind),
    .q_id   (q_id),
    .q_dist (q_dist)
  );

  knps_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({q_kind, q_id, q_dist}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (head_data)
  );

  knps_back #(
    .MAX_WANTED (MAX_WANTED),
    .DIST_W     (DIST_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wanted_count (wanted_count),
    .head_valid   (q_not_empty),
    .head_kind    (head_data[QW-1]),
    .head_id      (head_data[DIST_W +: ID_W]),
    .head_dist    (head_data[DIST_W-1:0]),
    .pop          (q_pop),
    .res          (result)
  );
endmodule

[test/tb.sv]
// testbench for the k-nearest point selector: directed table, random sets, scoreboard
module tb;
  import knps_pkg::*;

  localparam int COORD_W    = 24;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int KEEP_MAX   = 16;
  localparam int CLK_PERIOD = 8;
  localparam int SETTLE     = 20;
  localparam int REPORT_MAX = 10;
  localparam int RAND_ITEMS = 85;
  localparam int TIMEOUT_CYCLES = 200000;

  typedef struct {
    logic                      kind;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      rsv;
  } cand_beat_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
    status_t           status;
    logic              last;
  } answer_t;

  typedef enum {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t          op;
    cfg_idx_t           idx;
    logic [COORD_W-1:0] data;
    cand_beat_t         beat;
    bit                 typed;
    answer_t            want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  knps_cand_if #(.COORD_BITS(COORD_W)) cand_ch ();
  knps_res_if  #(.DIST_W(DIST_W))      res_ch ();

  k_nearest_point_selector_unit #(
    .MAX_WANTED(KEEP_MAX),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cand     (cand_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // own copy of the registers and the kept list
  logic signed [COORD_W-1:0] ref_px, ref_py, ref_pz;
  logic [WANT_W-1:0]         want_k;
  logic [ID_W-1:0]           near_id   [KEEP_MAX];
  logic [DIST_W-1:0]         near_dist [KEEP_MAX];
  int                        near_n;
  int                        elig_n;

  answer_t   answer_q[$];   // results the block still owes, oldest first
  answer_t   fresh_q[$];    // results caused by the beat just accepted
  stim_row_t dir_tab[$];
  answer_t   none_ans;
  int        mismatches;
  bit        steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic answer_t make_answer(logic [ID_W-1:0] id, logic [DIST_W-1:0] dsq,
                                          status_t st, logic last);
    answer_t a;
    a.id = id;
    a.dsq = dsq;
    a.status = st;
    a.last = last;
    return a;
  endfunction

  function automatic int sel_count();
    return (want_k > KEEP_MAX) ? KEEP_MAX : int'(want_k);
  endfunction

  function automatic logic [DIST_W-1:0] axis_sq(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return DIST_W'(d * d);
  endfunction

  // sorted insertion; ties go behind, the latest of equal far ones drops out
  function automatic void insert_near(logic [ID_W-1:0] id, logic [DIST_W-1:0] dsq);
    int k;
    int pos;
    int n;
    k = sel_count();
    pos = 0;
    if (k == 0) return;
    if (near_n > k) near_n = k;
    while (pos < near_n && near_dist[pos] <= dsq) pos++;
    if (near_n < k) begin
      n = near_n - pos;
    end else begin
      if (!(dsq < near_dist[k-1])) return;
      n = k - 1 - pos;
    end
    for (int i = pos + n; i > pos; i--) begin
      near_id[i]   = near_id[i-1];
      near_dist[i] = near_dist[i-1];
    end
    near_id[pos]   = id;
    near_dist[pos] = dsq;
    if (near_n < k) near_n++;
  endfunction

  // expected results of one accepted beat, into fresh_q
  function automatic void predict_beat(cand_beat_t b);
    int k;
    if (b.kind == KIND_CAND) begin
      if (!b.rsv) begin
        if (elig_n < int'(ELIG_MAX)) elig_n++;
        insert_near(b.id, axis_sq(b.x, ref_px) + axis_sq(b.y, ref_py) + axis_sq(b.z, ref_pz));
      end
      return;
    end
    k = sel_count();
    if (k == 0) begin
      fresh_q.push_back(make_answer('0, '0, STAT_NONE, 1'b1));
    end else if (elig_n < k || near_n < k) begin
      fresh_q.push_back(make_answer('0, '0, STAT_TOO_FEW, 1'b1));
    end else begin
      for (int i = 0; i < k; i++)
        fresh_q.push_back(make_answer(near_id[i], near_dist[i], STAT_ENTRY, i == k - 1));
    end
    near_n = 0;
    elig_n = 0;
  endfunction

  function automatic void predict_cfg(cfg_idx_t idx, logic [COORD_W-1:0] v);
    case (idx)
      CFG_REF_X:  ref_px = v;
      CFG_REF_Y:  ref_py = v;
      CFG_REF_Z:  ref_pz = v;
      CFG_WANTED: want_k = v[WANT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [COORD_W-1:0] v);
    stim_row_t r;
    r.op = ROW_CFG;
    r.idx = idx;
    r.data = v;
    r.beat = '{KIND_CAND, '0, '0, '0, '0, 1'b0};
    r.typed = 1'b0;
    r.want = none_ans;
    return r;
  endfunction

  function automatic stim_row_t beat_row(logic kind, logic [ID_W-1:0] id,
                                         logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [COORD_W-1:0] z, logic rsv,
                                         bit typed, answer_t want);
    stim_row_t r;
    r.op = ROW_BEAT;
    r.idx = CFG_REF_X;
    r.data = '0;
    r.beat = '{kind, id, x, y, z, rsv};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // near the reference (ties), anywhere, or at the ends of the range
  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] c);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return COORD_W'($urandom);
    if (r < 8) return c + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
    return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
  endfunction

  // one beat on the candidate channel, then its expectations
  task automatic send_beat(cand_beat_t b, bit typed, answer_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_ch.valid       <= 1'b1;
    cand_ch.kind        <= b.kind;
    cand_ch.cand_id     <= b.id;
    cand_ch.pos_x       <= b.x;
    cand_ch.pos_y       <= b.y;
    cand_ch.pos_z       <= b.z;
    cand_ch.is_reserved <= b.rsv;
    do @(posedge clk); while (cand_ch.ready !== 1'b1);
    predict_beat(b);
    if (typed) answer_q.push_back(want);
    else foreach (fresh_q[i]) answer_q.push_back(fresh_q[i]);
    fresh_q.delete();
  endtask

  // stop sending, let every owed result arrive and the pipe empty
  task automatic settle_idle();
    cand_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_cfg(idx, v);
    @(posedge clk);
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    int hold;
    int calm;
    int r;
    hold = 0;
    calm = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm = $urandom_range(20, 80);
          else if (r < 20) hold = $urandom_range(1, 3);
          else if (r < 23) hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result beat with nothing owed: id %h dist %0d status %0d last %0d",
                   res_ch.found_id, res_ch.found_dist_sq, res_ch.status, res_ch.last);
      end else begin
        e = answer_q.pop_front();
        if (res_ch.found_id !== e.id || res_ch.found_dist_sq !== e.dsq ||
            res_ch.status !== e.status || res_ch.last !== e.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"result mismatch: want id %h dist %0d status %0d last %0d,",
                      " got id %h dist %0d status %0d last %0d"},
                     e.id, e.dsq, e.status, e.last, res_ch.found_id,
                     res_ch.found_dist_sq, res_ch.status, res_ch.last);
        end
      end
    end
  end

  // run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    cand_beat_t         b;
    logic [COORD_W-1:0] rx, ry, rz, wd;
    int                 w;
    int                 k;
    int                 n;
    int                 sets;
    int                 phase;
    int                 rand_items;

    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_REF_X;
    cfg_data            <= '0;
    cand_ch.valid       <= 1'b0;
    cand_ch.kind        <= KIND_CAND;
    cand_ch.cand_id     <= '0;
    cand_ch.pos_x       <= '0;
    cand_ch.pos_y       <= '0;
    cand_ch.pos_z       <= '0;
    cand_ch.is_reserved <= 1'b0;
    ref_px = '0;
    ref_py = '0;
    ref_pz = '0;
    want_k = WANT_W'(1);
    near_n = 0;
    elig_n = 0;
    mismatches = 0;
    steady = 1'b0;
    none_ans = make_answer('0, '0, STAT_ENTRY, 1'b0);

    // directed table: reset defaults, extremes, none requested, too few, ties, count cut, saturation
    dir_tab.push_back(beat_row(KIND_END, 16'hA5A5, 24'h123456, 24'h800000, 24'h7FFFFF, 1'b1,
                               1, make_answer('0, '0, STAT_TOO_FEW, 1'b1)));
    dir_tab.push_back(beat_row(KIND_CAND, 16'h1234, 3, 4, 0, 1'b0, 0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0,
                               1, make_answer(16'h1234, 25, STAT_ENTRY, 1'b1)));
    dir_tab.push_back(cfg_row(CFG_WANTED, 0));
    dir_tab.push_back(beat_row(KIND_CAND, 7, 1, 1, 1, 1'b0, 0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0,
                               1, make_answer('0, '0, STAT_NONE, 1'b1)));
    dir_tab.push_back(cfg_row(CFG_REF_X, 24'h800000));
    dir_tab.push_back(cfg_row(CFG_REF_Y, 24'h7FFFFF));
    dir_tab.push_back(cfg_row(CFG_REF_Z, 24'h800000));
    dir_tab.push_back(cfg_row(CFG_WANTED, 1));
    dir_tab.push_back(beat_row(KIND_CAND, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0,
                               1, make_answer(16'hFFFF, 50'd844424829468675,
                                              STAT_ENTRY, 1'b1)));
    dir_tab.push_back(cfg_row(CFG_WANTED, 3));
    dir_tab.push_back(beat_row(KIND_CAND, 0, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 1, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0,
                               1, make_answer('0, '0, STAT_TOO_FEW, 1'b1)));
    // equal distances, a nearer one, then one tied with the farthest, then a strictly nearer one
    dir_tab.push_back(beat_row(KIND_CAND, 10, 24'h800002, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 11, 24'h800000, 24'h7FFFFD, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 12, 24'h800001, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 13, 24'h800000, 24'h7FFFFF, 24'h800002, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 14, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0, 0, none_ans));
    // count lowered in the middle of a set
    dir_tab.push_back(beat_row(KIND_CAND, 20, 24'h800003, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 21, 24'h800000, 24'h7FFFFF, 24'h800001, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_CAND, 22, 24'h800000, 24'h7FFFFB, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(cfg_row(CFG_WANTED, 2));
    dir_tab.push_back(beat_row(KIND_CAND, 23, 24'h800002, 24'h7FFFFF, 24'h800000, 1'b0,
                               0, none_ans));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0, 0, none_ans));
    // count above the maximum saturates
    dir_tab.push_back(cfg_row(CFG_WANTED, 31));
    dir_tab.push_back(beat_row(KIND_END, 0, 0, 0, 0, 1'b0,
                               1, make_answer('0, '0, STAT_TOO_FEW, 1'b1)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        settle_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random sets, a new register setting per phase
    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      settle_idle();
      case (phase % 8)
        0: w = 16;
        1: w = 1;
        2: w = 0;
        3: w = 31;
        4: w = 2;
        5: w = $urandom_range(3, 8);
        6: w = $urandom_range(17, 30);
        default: w = $urandom_range(0, 16);
      endcase
      case (phase % 4)
        0: begin
          rx = COORD_W'($urandom);
          ry = COORD_W'($urandom);
          rz = COORD_W'($urandom);
        end
        1: begin
          rx = ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
          ry = ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
          rz = ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
        end
        2: begin
          rx = '0;
          ry = '0;
          rz = '0;
        end
        default: begin
          rx = COORD_W'($urandom_range(0, 200)) - COORD_W'(100);
          ry = COORD_W'($urandom_range(0, 200)) - COORD_W'(100);
          rz = COORD_W'($urandom_range(0, 200)) - COORD_W'(100);
        end
      endcase
      wd = COORD_W'($urandom);
      wd[WANT_W-1:0] = WANT_W'(w);
      write_reg(CFG_REF_X, rx);
      write_reg(CFG_REF_Y, ry);
      write_reg(CFG_REF_Z, rz);
      write_reg(CFG_WANTED, wd);
      k = sel_count();
      steady = ($urandom_range(0, 3) == 0);
      sets = $urandom_range(1, 2);
      for (int s = 0; s < sets; s++) begin
        // mostly full sets, some short ones
        if ($urandom_range(0, 9) < 7) n = $urandom_range(k, k + 4);
        else n = $urandom_range(0, k + 2);
        for (int j = 0; j < n; j++) begin
          b.id   = ID_W'($urandom);
          b.x    = pick_coord(ref_px);
          b.y    = pick_coord(ref_py);
          b.z    = pick_coord(ref_pz);
          b.rsv  = ($urandom_range(0, 99) < 15);
          // a stray end item now and then breaks the set
          b.kind = ($urandom_range(0, 99) < 4) ? KIND_END : KIND_CAND;
          send_beat(b, 0, none_ans);
          rand_items++;
        end
        // the last set of a phase sometimes runs on into the next setting
        if (s != sets - 1 || $urandom_range(0, 3) != 0) begin
          b.kind = KIND_END;
          b.id   = ID_W'($urandom);
          b.x    = COORD_W'($urandom);
          b.y    = COORD_W'($urandom);
          b.z    = COORD_W'($urandom);
          b.rsv  = ($urandom_range(0, 1) != 0);
          send_beat(b, 0, none_ans);
          rand_items++;
        end
      end
      phase++;
    end

    // drain and finish
    settle_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

[files.f]
rtl/core/knps_pkg.sv
rtl/core/knps_cand_if.sv
rtl/core/knps_res_if.sv
rtl/core/knps_front.sv
rtl/core/knps_queue.sv
rtl/core/knps_back.sv
rtl/core/k_nearest_point_selector_unit.sv
test/tb.sv
